// ===== src/mm_pkg.sv =====
// Shared types, constants and helpers for the matrix multiply block.
// No dependencies; imported by mm_cell and matrix_multiply.
`default_nettype none
package mm_pkg;

  // Store geometry and arithmetic widths
  localparam int MAX_DIM   = 16;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ELEM_BITS = 16;
  localparam int PROD_W    = 2 * ELEM_BITS;
  localparam int SUM_W     = 40;
  localparam int CFG_W     = 5;
  localparam int CFG_AW    = 4;
  localparam int MAX_RES   = 16;
  localparam int COLS_MAX  = (MAX_DIM < MAX_RES) ? MAX_DIM : MAX_RES;

  // Input commands
  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_e;

  // Register map, by word index
  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_WAIT,
    ST_DRAIN,
    ST_ERR
  } state_e;

  // Token that walks the cell chain: one A element and its inner index
  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic [IDX_W-1:0]     k;
    logic [ELEM_BITS-1:0] a;
  } tok_t;

  // Write port into one cell's column of B
  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     row;
    logic [ELEM_BITS-1:0] data;
  } bwr_t;

  // Chain-wide control
  typedef struct packed {
    logic start;
    logic shift;
  } ctl_t;

  // Map a raw size register onto 1..hi
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/matrix_multiply.sv =====
// Top level of the matrix multiply block: register port, A store, sequencer
// and the chain of mm_cell instances. Depends on mm_pkg and mm_cell.
//
// Usage: load beats (command 0 for A, 1 for B) write one Q8.8 element each;
// loads outside the configured sizes are dropped. A compute beat (command 2)
// names a result row i; the block then delivers cols_b result beats
// C(i,0..cols_b-1), each an exact Q24.16 sum, with last set on the final
// one. A row not below rows_a gives one beat with error and last set and a
// zero sum.
// Flow: the row of A streams from the A store one element a cycle into
// a chain of 16 cells, one per result column; each cell multiplies by its
// own column of B and accumulates. Once the last cell has summed its final
// product, results follow one per cycle while the receiver is ready,
// as the sums shift out of the chain. One item is worked on at a time:
// in_ready is low from the compute beat until its last result is taken.
// Reset clears control and sets all three size registers to 16; the
// element stores are not cleared. A stalled receiver simply holds the
// current result and the chain.
`default_nettype none
module matrix_multiply
  import mm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // APB-style register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // Input channel
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        command_i,
  input  wire logic [3:0]        row_i,
  input  wire logic [3:0]        col_i,
  input  wire logic [15:0]       value_i,
  // Output channel
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [3:0]             result_col_o,
  output logic [SUM_W-1:0]       sum_o,
  output logic                   error_o,
  output logic                   last_o
);

  logic [CFG_W-1:0]     rows_a_q, inner_dim_q, cols_b_q;
  logic [CFG_W-1:0]     nr, nk, nc;
  logic [IDX_W-1:0]     nk_m1, nc_m1;
  logic                 cfg_wr;
  reg_e                 cfg_idx;

  state_e               state_d, state_q;
  logic [IDX_W-1:0]     row_d, row_q;
  logic [IDX_W-1:0]     k_d, k_q;
  logic [IDX_W-1:0]     col_d, col_q;
  logic                 fvld_d, fvld_q;
  logic                 flast_d, flast_q;
  logic [IDX_W-1:0]     fk_q;
  logic                 in_acc, out_acc;
  logic                 amem_we, bwr_we;
  ctl_t                 ctl;

  logic [ELEM_BITS-1:0] amem [MAX_DIM*MAX_DIM];
  logic [ELEM_BITS-1:0] arow_q;

  tok_t                 tok [MAX_DIM+1];
  logic [SUM_W-1:0]     acc [MAX_DIM+1];
  logic [MAX_DIM-1:0]   cell_done;

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_e'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= CFG_W'(16);
      inner_dim_q <= CFG_W'(16);
      cols_b_q    <= CFG_W'(16);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROWS_A:    rows_a_q    <= pwdata[CFG_W-1:0];
        REG_INNER_DIM: inner_dim_q <= pwdata[CFG_W-1:0];
        REG_COLS_B:    cols_b_q    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROWS_A:    prdata = {{(32-CFG_W){1'b0}}, rows_a_q};
      REG_INNER_DIM: prdata = {{(32-CFG_W){1'b0}}, inner_dim_q};
      REG_COLS_B:    prdata = {{(32-CFG_W){1'b0}}, cols_b_q};
      default:       prdata = '0;
    endcase
  end

  // Effective sizes
  assign nr    = clamp_dim(rows_a_q, CFG_W'(MAX_DIM));
  assign nk    = clamp_dim(inner_dim_q, CFG_W'(MAX_DIM));
  assign nc    = clamp_dim(cols_b_q, CFG_W'(COLS_MAX));
  assign nk_m1 = IDX_W'(nk - CFG_W'(1));
  assign nc_m1 = IDX_W'(nc - CFG_W'(1));

  // Handshakes
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_DRAIN) || (state_q == ST_ERR);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;

  // Load decode
  assign amem_we = in_acc && (cmd_e'(command_i) == CMD_LOAD_A)
                   && ({1'b0, row_i} < nr) && ({1'b0, col_i} < nk);
  assign bwr_we  = in_acc && (cmd_e'(command_i) == CMD_LOAD_B)
                   && ({1'b0, row_i} < nk) && ({1'b0, col_i} < nc);

  // Sequencer: next state and outputs
  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    k_d       = k_q;
    col_d     = col_q;
    fvld_d    = 1'b0;
    flast_d   = 1'b0;
    ctl.start = 1'b0;
    ctl.shift = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (cmd_e'(command_i) == CMD_COMPUTE)) begin
          row_d = row_i;
          k_d   = '0;
          col_d = '0;
          if ({1'b0, row_i} < nr) begin
            ctl.start = 1'b1;
            state_d   = ST_FEED;
          end else begin
            state_d = ST_ERR;
          end
        end
      end
      ST_FEED: begin
        fvld_d  = 1'b1;
        flast_d = (k_q == nk_m1);
        k_d     = k_q + IDX_W'(1);
        if (k_q == nk_m1) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (cell_done[MAX_DIM-1]) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_ready_i) begin
          ctl.shift = 1'b1;
          col_d     = col_q + IDX_W'(1);
          if (col_q == nc_m1) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      k_q     <= '0;
      col_q   <= '0;
      fvld_q  <= 1'b0;
      flast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      k_q     <= k_d;
      col_q   <= col_d;
      fvld_q  <= fvld_d;
      flast_q <= flast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fk_q <= k_q;
  end

  // A store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (amem_we) begin
      amem[{row_i, col_i}] <= value_i[ELEM_BITS-1:0];
    end
    arow_q <= amem[{row_q, k_q}];
  end

  // Head of the chain
  assign tok[0].vld  = fvld_q;
  assign tok[0].last = flast_q;
  assign tok[0].k    = fk_q;
  assign tok[0].a    = arow_q;
  assign acc[MAX_DIM] = '0;

  // Chain of cells, one per result column
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    bwr_t bwr;

    assign bwr.we   = bwr_we && (col_i == IDX_W'(j));
    assign bwr.row  = row_i;
    assign bwr.data = value_i[ELEM_BITS-1:0];

    mm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .bwr_i  (bwr),
      .tok_i  (tok[j]),
      .tok_o  (tok[j+1]),
      .acc_i  (acc[j+1]),
      .acc_o  (acc[j]),
      .done_o (cell_done[j])
    );
  end

  // Result beat
  assign result_col_o = col_q;
  assign error_o      = (state_q == ST_ERR);
  assign sum_o        = (state_q == ST_ERR) ? '0 : acc[0];
  assign last_o       = (state_q == ST_ERR) || (col_q == nc_m1);

  // Checks
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output sides active together");

  a_tail_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok[MAX_DIM].vld && tok[MAX_DIM].last) |-> ##2 cell_done[MAX_DIM-1])
    else $error("last cell did not finish two cycles after the final token");

  a_all_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_done[MAX_DIM-1] |-> (&cell_done))
    else $error("tail cell done before an earlier cell");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_o) |=> in_ready_o)
    else $error("block not idle after the final result beat");

endmodule
`default_nettype wire

// ===== src/mm_cell.sv =====
// One cell of the multiply chain: holds one column of B and one accumulator.
// Depends on mm_pkg for the token, write and control types.
`default_nettype none
module mm_cell
  import mm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctl_t             ctl_i,
  input  wire bwr_t             bwr_i,
  input  wire tok_t             tok_i,
  output tok_t                  tok_o,
  input  wire logic [SUM_W-1:0] acc_i,
  output logic [SUM_W-1:0]      acc_o,
  output logic                  done_o
);

  logic [ELEM_BITS-1:0] bcol_q [MAX_DIM];
  tok_t                 tok_q;
  logic [ELEM_BITS-1:0] bsel;
  logic [PROD_W-1:0]    prod_d, prod_q;
  logic                 pvld_q, plast_q;
  logic [SUM_W-1:0]     acc_q;
  logic                 done_q;

  // Write one element of this column of B
  always_ff @(posedge clk_i) begin
    if (bwr_i.we) begin
      bcol_q[bwr_i.row] <= bwr_i.data;
    end
  end

  // Advance the token one cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign tok_o = tok_q;

  // Multiply the passing A element by B(k, this column)
  assign bsel   = bcol_q[tok_q.k];
  assign prod_d = PROD_W'($signed(tok_q.a) * $signed(bsel));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q  <= 1'b0;
      plast_q <= 1'b0;
    end else begin
      pvld_q  <= tok_q.vld;
      plast_q <= tok_q.vld & tok_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Clear, accumulate, or shift the sum toward the head of the chain
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q <= '0;
    end else if (ctl_i.shift) begin
      acc_q <= acc_i;
    end else if (pvld_q) begin
      acc_q <= acc_q + {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // Flag the final product of the row as summed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (ctl_i.start) begin
      done_q <= 1'b0;
    end else if (pvld_q && plast_q) begin
      done_q <= 1'b1;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule
`default_nettype wire
